>>> sv/bcv_pkg.sv
// bcv_pkg: discharge curves and widths for battery_charge_from_voltage
// holds the breakpoint constants, per-segment reciprocals and curve lookup functions
// no dependencies
package bcv_pkg;

   localparam int TABLE_POINTS       = 12;
   localparam int DEF_CURVE_POINTS   = 12;
   localparam int MV_W               = 12;
   localparam int PCT_W              = 7;
   localparam int PT_W               = $clog2(TABLE_POINTS);
   localparam int PROD_W             = MV_W + PCT_W;
   localparam int RECIP_SHIFT        = 20;
   localparam int RECIP_W            = 18;
   localparam int SCALED_W           = PROD_W + RECIP_W;

   typedef logic [MV_W-1:0]    mv_type;
   typedef logic [PCT_W-1:0]   pct_type;
   typedef logic [PT_W-1:0]    pt_type;
   typedef logic [RECIP_W-1:0] recip_type;

   localparam mv_type NIMH_MV [TABLE_POINTS] = '{
      12'd1000, 12'd1130, 12'd1200, 12'd1242, 12'd1258, 12'd1268,
      12'd1275, 12'd1282, 12'd1290, 12'd1305, 12'd1340, 12'd1450};
   localparam pct_type NIMH_PCT [TABLE_POINTS] = '{
      7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
      7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100};
   localparam mv_type ALK_MV [TABLE_POINTS] = '{
      12'd800, 12'd900, 12'd1000, 12'd1100, 12'd1200, 12'd1250,
      12'd1300, 12'd1350, 12'd1400, 12'd1450, 12'd1500, 12'd1520};
   localparam pct_type ALK_PCT [TABLE_POINTS] = '{
      7'd0, 7'd5, 7'd12, 7'd25, 7'd45, 7'd58,
      7'd70, 7'd80, 7'd88, 7'd94, 7'd98, 7'd100};

   // floor(2**RECIP_SHIFT / segment mV step), one per segment
   localparam recip_type NIMH_RECIP [TABLE_POINTS-1] = '{
      18'd8065, 18'd14979, 18'd24966, 18'd65536, 18'd104857, 18'd149796,
      18'd149796, 18'd131072, 18'd69905, 18'd29959, 18'd9532};
   localparam recip_type ALK_RECIP [TABLE_POINTS-1] = '{
      18'd10485, 18'd10485, 18'd10485, 18'd10485, 18'd20971, 18'd20971,
      18'd20971, 18'd20971, 18'd20971, 18'd20971, 18'd52428};

   function automatic mv_type curve_mv(input logic kind, input pt_type idx);
      mv_type r;
      r = '0;
      if (idx < PT_W'(TABLE_POINTS)) begin
         r = kind ? ALK_MV[idx] : NIMH_MV[idx];
      end
      return r;
   endfunction

   function automatic pct_type curve_pct(input logic kind, input pt_type idx);
      pct_type r;
      r = '0;
      if (idx < PT_W'(TABLE_POINTS)) begin
         r = kind ? ALK_PCT[idx] : NIMH_PCT[idx];
      end
      return r;
   endfunction

   function automatic recip_type seg_recip(input logic kind, input pt_type seg);
      recip_type r;
      r = '0;
      if (seg < PT_W'(TABLE_POINTS - 1)) begin
         r = kind ? ALK_RECIP[seg] : NIMH_RECIP[seg];
      end
      return r;
   endfunction

   // mV step of a segment; every segment in the curves rises
   function automatic mv_type seg_dmv(input logic kind, input pt_type seg);
      return curve_mv(kind, seg + PT_W'(1)) - curve_mv(kind, seg);
   endfunction

   // percent step of a segment, zero where the curve would fall
   function automatic pct_type seg_dp(input logic kind, input pt_type seg);
      pct_type lo_p;
      pct_type hi_p;
      lo_p = curve_pct(kind, seg);
      hi_p = curve_pct(kind, seg + PT_W'(1));
      return (hi_p >= lo_p) ? (hi_p - lo_p) : '0;
   endfunction

endpackage

>>> sv/battery_charge_from_voltage.sv
// battery_charge_from_voltage: cell millivolts to state-of-charge percent
// six-stage pipeline: segment search, offset, multiply, reciprocal divide, correction
// depends on bcv_pkg
//
// One item a clock: start may be high in every cycle and busy never rises. The
// charge estimate leaves on rsp_charge_percent with rsp_valid high for one cycle;
// the receiver cannot stall, so the pipeline never holds. The depth is set by the
// reciprocal divide, which takes a multiply, a back-multiply and a correction
// step on a register each. The curve register csr_battery_kind is always
// writable and should change only while no item is in flight.
module battery_charge_from_voltage #(
   parameter int CURVE_POINTS = bcv_pkg::DEF_CURVE_POINTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [bcv_pkg::MV_W-1:0]   req_cell_millivolts,
   output logic                       rsp_valid,
   output logic [bcv_pkg::PCT_W-1:0]  rsp_charge_percent,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_battery_kind
);
   import bcv_pkg::*;

   localparam int POINTS_USED = (CURVE_POINTS > TABLE_POINTS) ? TABLE_POINTS :
                                (CURVE_POINTS < 1) ? 1 : CURVE_POINTS;
   localparam int DEF_SEG     = (POINTS_USED > 1) ? POINTS_USED - 2 : 0;

   logic kind_ff;

   // stage 1: segment search
   logic    s1_valid_ff;
   logic    s1_kind_ff;
   mv_type  s1_sample_ff;
   pt_type  s1_seg_ff;
   logic    s1_below_ff;
   logic    s1_above_ff;
   pt_type  seg_in;
   logic    below_in;
   logic    above_in;

   // stage 2: offset into segment, base percent
   logic    s2_valid_ff;
   logic    s2_kind_ff;
   pt_type  s2_seg_ff;
   mv_type  s2_diff_ff;
   pct_type s2_dp_ff;
   pct_type s2_base_ff;
   pct_type base_in;
   pct_type dp_in;

   // stage 3: product
   logic                s3_valid_ff;
   logic                s3_kind_ff;
   pt_type              s3_seg_ff;
   logic [PROD_W-1:0]   s3_prod_ff;
   pct_type             s3_base_ff;

   // stage 4: quotient estimate, low by at most one
   logic                s4_valid_ff;
   logic                s4_kind_ff;
   pt_type              s4_seg_ff;
   logic [PROD_W-1:0]   s4_prod_ff;
   pct_type             s4_base_ff;
   pct_type             s4_q_ff;
   logic [SCALED_W-1:0] scaled_in;

   // stage 5: back-multiply
   logic                s5_valid_ff;
   logic [PROD_W-1:0]   s5_prod_ff;
   logic [PROD_W-1:0]   s5_qd_ff;
   mv_type              s5_dmv_ff;
   pct_type             s5_base_ff;
   pct_type             s5_q_ff;
   pct_type             q_fix_in;

   logic                rsp_valid_ff;
   pct_type             rsp_pct_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         kind_ff <= csr_battery_kind;
      end
   end

   // first breakpoint at or above the sample picks the segment
   always_comb begin
      below_in = (req_cell_millivolts <= curve_mv(kind_ff, '0));
      above_in = 1'b1;
      seg_in   = PT_W'(DEF_SEG);
      for (int i = POINTS_USED - 1; i >= 1; i--) begin
         if (req_cell_millivolts <= curve_mv(kind_ff, PT_W'(i))) begin
            above_in = 1'b0;
            seg_in   = PT_W'(i - 1);
         end
      end
   end

   // clamped items get a zero step so the divide yields nothing
   always_comb begin
      base_in = curve_pct(s1_kind_ff, s1_seg_ff);
      dp_in   = seg_dp(s1_kind_ff, s1_seg_ff);
      if (s1_below_ff) begin
         base_in = curve_pct(s1_kind_ff, '0);
         dp_in   = '0;
      end else if (s1_above_ff) begin
         base_in = curve_pct(s1_kind_ff, PT_W'(POINTS_USED - 1));
         dp_in   = '0;
      end
   end

   assign scaled_in = SCALED_W'(s3_prod_ff) * SCALED_W'(seg_recip(s3_kind_ff, s3_seg_ff));

   assign q_fix_in = (s5_prod_ff >= s5_qd_ff + PROD_W'(s5_dmv_ff)) ?
                     s5_q_ff + PCT_W'(1) : s5_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff   <= kind_ff;
      s1_sample_ff <= req_cell_millivolts;
      s1_seg_ff    <= seg_in;
      s1_below_ff  <= below_in;
      s1_above_ff  <= above_in;

      s2_kind_ff   <= s1_kind_ff;
      s2_seg_ff    <= s1_seg_ff;
      s2_diff_ff   <= s1_sample_ff - curve_mv(s1_kind_ff, s1_seg_ff);
      s2_dp_ff     <= dp_in;
      s2_base_ff   <= base_in;

      s3_kind_ff   <= s2_kind_ff;
      s3_seg_ff    <= s2_seg_ff;
      s3_prod_ff   <= PROD_W'(s2_diff_ff) * PROD_W'(s2_dp_ff);
      s3_base_ff   <= s2_base_ff;

      s4_kind_ff   <= s3_kind_ff;
      s4_seg_ff    <= s3_seg_ff;
      s4_prod_ff   <= s3_prod_ff;
      s4_base_ff   <= s3_base_ff;
      s4_q_ff      <= scaled_in[RECIP_SHIFT +: PCT_W];

      s5_prod_ff   <= s4_prod_ff;
      s5_qd_ff     <= PROD_W'(s4_q_ff) * PROD_W'(seg_dmv(s4_kind_ff, s4_seg_ff));
      s5_dmv_ff    <= seg_dmv(s4_kind_ff, s4_seg_ff);
      s5_base_ff   <= s4_base_ff;
      s5_q_ff      <= s4_q_ff;

      rsp_pct_ff   <= s5_base_ff + q_fix_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_charge_percent = rsp_pct_ff;

endmodule

>>> sim/charge_estimate_check.sv
// charge_estimate_check: watches the sample, result and curve-select channels of
// battery_charge_from_voltage, predicts each charge estimate and compares it in order
// depends on bcv_pkg
`timescale 1ns / 100ps

module charge_estimate_check #(
   parameter int CURVE_POINTS = bcv_pkg::DEF_CURVE_POINTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  bcv_pkg::mv_type           req_cell_millivolts,
   input  logic                      rsp_valid,
   input  bcv_pkg::pct_type          rsp_charge_percent,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic                      csr_battery_kind,
   output int                        fail_count,
   output int                        pending
);

   localparam int NPTS = 12;
   localparam int NIMH_MV_PTS [NPTS] = '{
      1000, 1130, 1200, 1242, 1258, 1268, 1275, 1282, 1290, 1305, 1340, 1450};
   localparam int NIMH_PCT_PTS [NPTS] = '{
      0, 5, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100};
   localparam int ALK_MV_PTS [NPTS] = '{
      800, 900, 1000, 1100, 1200, 1250, 1300, 1350, 1400, 1450, 1500, 1520};
   localparam int ALK_PCT_PTS [NPTS] = '{
      0, 5, 12, 25, 45, 58, 70, 80, 88, 94, 98, 100};

   logic             alkaline;
   bcv_pkg::pct_type expected_percent [$];
   bcv_pkg::mv_type  sample_of [$];
   int               mismatches;

   function automatic bcv_pkg::pct_type charge_from_curve(input logic alk,
                                                          input bcv_pkg::mv_type sample);
      int mv_pt [NPTS];
      int pct_pt [NPTS];
      int n;
      int i;
      int s;
      int step_p;
      for (i = 0; i < NPTS; i++) begin
         mv_pt[i]  = alk ? ALK_MV_PTS[i] : NIMH_MV_PTS[i];
         pct_pt[i] = alk ? ALK_PCT_PTS[i] : NIMH_PCT_PTS[i];
      end
      n = CURVE_POINTS;
      if (n < 1) n = 1;
      if (n > NPTS) n = NPTS;
      s = int'(sample);
      if (s <= mv_pt[0]) return bcv_pkg::pct_type'(pct_pt[0]);
      for (i = 1; i < n; i++) begin
         if (s <= mv_pt[i]) begin
            step_p = (pct_pt[i] >= pct_pt[i-1]) ? pct_pt[i] - pct_pt[i-1] : 0;
            if (mv_pt[i] == mv_pt[i-1]) return bcv_pkg::pct_type'(pct_pt[i-1]);
            return bcv_pkg::pct_type'(pct_pt[i-1]
                   + ((s - mv_pt[i-1]) * step_p) / (mv_pt[i] - mv_pt[i-1]));
         end
      end
      return bcv_pkg::pct_type'(pct_pt[n-1]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         alkaline = 1'b0;
         expected_percent.delete();
         sample_of.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_percent.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: charge estimate %0d with no item outstanding",
                           $time, rsp_charge_percent);
            end else begin
               if (rsp_charge_percent !== expected_percent[0]) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: %0d mV: charge_percent expected %0d got %0d",
                              $time, sample_of[0], expected_percent[0],
                              rsp_charge_percent);
               end
               void'(expected_percent.pop_front());
               void'(sample_of.pop_front());
            end
         end
         // the item taken on this edge still sees the curve in force before it
         if (start && !busy) begin
            expected_percent.push_back(charge_from_curve(alkaline, req_cell_millivolts));
            sample_of.push_back(req_cell_millivolts);
         end
         if (csr_valid && csr_ready) alkaline = csr_battery_kind;
      end
      pending = expected_percent.size();
   end

endmodule

>>> sim/battery_charge_from_voltage_test.sv
// battery_charge_from_voltage_test: stimulus and verdict for battery_charge_from_voltage
// drives samples and curve selects; checking lives in charge_estimate_check
// depends on bcv_pkg, battery_charge_from_voltage and charge_estimate_check
`timescale 1ns / 100ps

module battery_charge_from_voltage_test;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PIPE_SETTLE  = 10;
   localparam int CHUNK_ITEMS  = 75;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   bcv_pkg::mv_type      req_cell_millivolts;
   logic                 rsp_valid;
   bcv_pkg::pct_type     rsp_charge_percent;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_battery_kind;
   int                   fail_count;
   int                   pending;
   int                   cycles;
   int                   sender_idle_pct;
   bcv_pkg::mv_type      mv;

   battery_charge_from_voltage dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cell_millivolts (req_cell_millivolts),
      .rsp_valid           (rsp_valid),
      .rsp_charge_percent  (rsp_charge_percent),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_battery_kind    (csr_battery_kind)
   );

   charge_estimate_check check (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cell_millivolts (req_cell_millivolts),
      .rsp_valid           (rsp_valid),
      .rsp_charge_percent  (rsp_charge_percent),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_battery_kind    (csr_battery_kind),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** battery_charge_from_voltage: FAILED **");
         $finish;
      end
   end

   task automatic send_sample(input bcv_pkg::mv_type sample);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start               <= 1'b0;
         req_cell_millivolts <= bcv_pkg::mv_type'($urandom);
         @(negedge clock);
      end
      start               <= 1'b1;
      req_cell_millivolts <= sample;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic select_curve(input logic alk);
      drain();
      csr_valid        <= 1'b1;
      csr_battery_kind <= alk;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_cell_millivolts = '0;
      csr_valid           = 1'b0;
      csr_battery_kind    = 1'b0;
      sender_idle_pct     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nickel-metal-hydride curve: floor, first segment edges, top clamp
      select_curve(1'b0);
      send_sample(12'd0);
      send_sample(12'd1000);
      send_sample(12'd1001);
      send_sample(12'd1129);
      send_sample(12'd1130);
      send_sample(12'd1449);
      send_sample(12'd1450);
      send_sample(12'd1451);
      send_sample(12'd4095);
      // alkaline curve
      select_curve(1'b1);
      send_sample(12'd0);
      send_sample(12'd800);
      send_sample(12'd801);
      send_sample(12'd899);
      send_sample(12'd1519);
      send_sample(12'd1520);
      send_sample(12'd1521);
      send_sample(12'd2048);
      send_sample(12'd4095);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 66 : 0;
         for (int chunk = 0; chunk < 2; chunk++) begin
            if (phase == 2) select_curve(logic'($urandom_range(0, 1)));
            else select_curve(logic'(chunk ^ (phase == 0)));
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
               case ($urandom_range(0, 9))
                  0, 1: mv = bcv_pkg::mv_type'($urandom_range(0, 4095));
                  // crowd the ends of both curves
                  2: mv = $urandom_range(0, 1) ? bcv_pkg::mv_type'($urandom_range(1440, 1530))
                                               : bcv_pkg::mv_type'($urandom_range(790, 1010));
                  default: mv = bcv_pkg::mv_type'($urandom_range(780, 1540));
               endcase
               send_sample(mv);
            end
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("** battery_charge_from_voltage: PASSED **");
      end else begin
         $display("** battery_charge_from_voltage: FAILED **");
      end
      $finish;
   end

endmodule
